>>> sv/riff_wave_header_parser_defines.svh
// Assertion macros used by the RIFF/WAVE header parser top level
`ifndef RIFF_WAVE_HEADER_PARSER_DEFINES_SVH
`define RIFF_WAVE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RWHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/rwhp_pkg.sv
// Package: types, codes and command/status structs of the RIFF/WAVE header parser
`default_nettype none
package rwhp_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] pcm_offset;
    logic [31:0] data_size;
    logic [31:0] frame_count;
  } out_item_t;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_RIFF       = 3'd1;
  localparam logic [2:0] ST_NO_WAVE       = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT     = 3'd3;
  localparam logic [2:0] ST_NOT_PCM       = 3'd4;
  localparam logic [2:0] ST_CHUNK_MISSING = 3'd5;
  localparam logic [2:0] ST_MISMATCH      = 3'd6;
  localparam logic [2:0] ST_ZERO_FRAME    = 3'd7;

  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_RATE     = 2'd1;
  localparam logic [1:0] CFG_BITS     = 2'd2;

  localparam logic [15:0] RST_CHANNELS = 16'd1;
  localparam logic [31:0] RST_RATE     = 32'd16000;
  localparam logic [15:0] RST_BITS     = 16'd16;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  typedef enum logic [4:0] {
    P_IDLE, P_RIFF, P_RIFFSIZE, P_WAVE, P_ID, P_SZ_FMT, P_SZ_DATA, P_SZ_OTHER,
    P_F_FORMAT, P_F_CHAN, P_F_RATE, P_F_BRATE, P_F_ALIGN, P_F_BITS, P_SKIP,
    P_DONE, P_MUL, P_ZCHK, P_DIV
  } phase_t;

  typedef enum logic [1:0] {SRC_ZERO, SRC_NOW, SRC_HELD} src_t;

  typedef struct packed {
    logic       clear;
    logic       pos_inc;
    logic       gather_en;
    logic       gather_n2;
    logic       ld_chunk;
    logic       ld_skip_other;
    logic       ld_skip_fmt;
    logic       skip_dec;
    logic       ld_format;
    logic       ld_chan;
    logic       ld_rate;
    logic       ld_bits;
    logic       set_fmt;
    logic       ld_data;
    logic       mul_go;
    logic       div_start;
    logic       div_step;
    logic       emit;
    logic [2:0] emit_status;
    src_t       emit_src;
  } cmd_t;

  typedef struct packed {
    logic field_done;
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic size_lt16;
    logic size_zero;
    logic fmt_rest_zero;
    logic fmt_seen;
    logic cfg_match;
    logic format_pcm;
    logic skip_last;
    logic bpf_zero;
    logic div_last;
    logic out_pending;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/riff_wave_header_parser.sv
// Top level: RIFF/WAVE header parser, controller plus datapath
`default_nettype none
`include "riff_wave_header_parser_defines.svh"
// Takes one file byte per cycle while parsing the header: every byte, including
// skipped chunk bodies, is accepted in a single cycle. Once the data chunk size
// is read after a PCM format that matches the settings, the frame count is worked
// out by a bytes-per-frame multiply, a zero check, then a restoring divider,
// during which no byte is accepted; a zero frame size is reported at the zero
// check. Each file gives exactly one result; no new byte is accepted while a
// result waits in the output register. A byte with first_byte set restarts
// parsing at byte 0.
module riff_wave_header_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rwhp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rwhp_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  rwhp_pkg::cmd_t  cmd;
  rwhp_pkg::stat_t stat;

  rwhp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwhp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RWHP_ASSERT_NOW(a_no_accept_while_pending, in_valid && in_ready, !out_valid)
  `RWHP_ASSERT_NOW(a_frames_only_ok, out_valid && (out_data.status != rwhp_pkg::ST_OK), out_data.frame_count == 32'd0)
  `RWHP_ASSERT_NOW(a_early_error_no_data, out_valid && (out_data.status == rwhp_pkg::ST_NO_RIFF || out_data.status == rwhp_pkg::ST_NO_WAVE || out_data.status == rwhp_pkg::ST_FMT_SHORT || out_data.status == rwhp_pkg::ST_NOT_PCM), out_data.data_size == 32'd0 && out_data.pcm_offset == 32'd0)
  `RWHP_ASSERT_NEXT(a_single_result, out_valid && out_ready, !out_valid)

endmodule
`default_nettype wire

>>> sv/rwhp_dpath.sv
// Datapath: field gathering, header registers, frame divider and result register
`default_nettype none
module rwhp_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rwhp_pkg::in_item_t in_data,
  input  wire rwhp_pkg::cmd_t    cmd,
  output rwhp_pkg::stat_t        stat,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rwhp_pkg::out_item_t    out_data
);

  logic [15:0] cfg_ch_r, cfg_bits_r;
  logic [31:0] cfg_rate_r;
  logic [1:0]  idx_r, idx_nxt, idx_eff;
  logic [31:0] shift_r, shift_nxt, shift_eff, fv;
  logic [31:0] pos_r, pos_nxt, pos_eff;
  logic [31:0] chunk_r, chunk_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic        fmt_r, fmt_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] ch_r, ch_nxt, bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] doff_r, doff_nxt, dsize_r, dsize_nxt;
  logic [28:0] bpf_r, bpf_nxt;
  logic [31:0] q_r, q_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [29:0] rem_sh, rem_sub;
  logic        ge;
  logic        out_valid_r, out_valid_nxt;
  rwhp_pkg::out_item_t out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch_r   <= rwhp_pkg::RST_CHANNELS;
      cfg_rate_r <= rwhp_pkg::RST_RATE;
      cfg_bits_r <= rwhp_pkg::RST_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        rwhp_pkg::CFG_CHANNELS: cfg_ch_r <= cfg_wdata[15:0];
        rwhp_pkg::CFG_RATE:     cfg_rate_r <= cfg_wdata;
        rwhp_pkg::CFG_BITS:     cfg_bits_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_eff   = cmd.clear ? 2'd0 : idx_r;
    shift_eff = cmd.clear ? 32'd0 : shift_r;
    pos_eff   = cmd.clear ? 32'd0 : pos_r;
    fv        = shift_eff | ({24'd0, in_data.file_byte} << {idx_eff, 3'b000});
    stat.field_done = cmd.gather_n2 ? (idx_eff != 2'd0) : (idx_eff == 2'd3);

    idx_nxt   = idx_eff;
    shift_nxt = shift_eff;
    if (cmd.gather_en) begin
      if (stat.field_done) begin
        idx_nxt   = 2'd0;
        shift_nxt = 32'd0;
      end else begin
        idx_nxt   = idx_eff + 2'd1;
        shift_nxt = fv;
      end
    end
    pos_nxt = cmd.pos_inc ? pos_eff + 32'd1 : pos_r;

    chunk_nxt = cmd.ld_chunk ? fv : chunk_r;
    skip_nxt  = skip_r;
    if (cmd.ld_skip_other) skip_nxt = {1'b0, fv} + {32'd0, fv[0]};
    else if (cmd.ld_skip_fmt) skip_nxt = {1'b0, chunk_r - rwhp_pkg::FMT_BASE_LEN};
    else if (cmd.skip_dec) skip_nxt = skip_r - 33'd1;

    fmt_nxt    = cmd.set_fmt | (!cmd.clear & fmt_r);
    format_nxt = cmd.ld_format ? fv[15:0] : (cmd.clear ? 16'd0 : format_r);
    ch_nxt     = cmd.ld_chan ? fv[15:0] : (cmd.clear ? 16'd0 : ch_r);
    rate_nxt   = cmd.ld_rate ? fv : (cmd.clear ? 32'd0 : rate_r);
    bits_nxt   = cmd.ld_bits ? fv[15:0] : (cmd.clear ? 16'd0 : bits_r);
    doff_nxt   = cmd.ld_data ? pos_eff + 32'd1 : doff_r;
    dsize_nxt  = cmd.ld_data ? fv : dsize_r;
    bpf_nxt    = cmd.mul_go ? bits_r[15:3] * ch_r : bpf_r;

    rem_sh  = {rem_r, q_r[31]};
    rem_sub = rem_sh - {1'b0, bpf_r};
    ge      = rem_sh >= {1'b0, bpf_r};
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.div_start) begin
      q_nxt   = dsize_r;
      rem_nxt = 29'd0;
      cnt_nxt = 5'd0;
    end else if (cmd.div_step) begin
      q_nxt   = {q_r[30:0], ge};
      rem_nxt = ge ? rem_sub[28:0] : rem_sh[28:0];
      cnt_nxt = cnt_r + 5'd1;
    end

    stat.tag_riff      = fv == rwhp_pkg::TAG_RIFF;
    stat.tag_wave      = fv == rwhp_pkg::TAG_WAVE;
    stat.tag_fmt       = fv == rwhp_pkg::TAG_FMT;
    stat.tag_data      = fv == rwhp_pkg::TAG_DATA;
    stat.size_lt16     = fv < rwhp_pkg::FMT_BASE_LEN;
    stat.size_zero     = fv == 32'd0;
    stat.fmt_rest_zero = chunk_r == rwhp_pkg::FMT_BASE_LEN;
    stat.fmt_seen      = fmt_r;
    stat.cfg_match     = (ch_r == cfg_ch_r) && (rate_r == cfg_rate_r) &&
                         (bits_r == cfg_bits_r);
    stat.format_pcm    = format_r == rwhp_pkg::FMT_PCM;
    stat.skip_last     = skip_r <= 33'd1;
    stat.bpf_zero      = bpf_r == 29'd0;
    stat.div_last      = cnt_r == 5'd31;
    stat.out_pending   = out_valid_r;

    out_valid_nxt = cmd.emit | (out_valid_r & !out_ready);
    out_nxt       = out_r;
    if (cmd.emit) begin
      out_nxt.status        = cmd.emit_status;
      out_nxt.channel_count = ch_nxt;
      out_nxt.rate_hz       = rate_nxt;
      out_nxt.sample_bits   = bits_nxt;
      case (cmd.emit_src)
        rwhp_pkg::SRC_NOW: begin
          out_nxt.pcm_offset = pos_eff + 32'd1;
          out_nxt.data_size  = fv;
        end
        rwhp_pkg::SRC_HELD: begin
          out_nxt.pcm_offset = doff_r;
          out_nxt.data_size  = dsize_r;
        end
        default: begin
          out_nxt.pcm_offset = 32'd0;
          out_nxt.data_size  = 32'd0;
        end
      endcase
      out_nxt.frame_count = (cmd.emit_status == rwhp_pkg::ST_OK) ? q_nxt : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      shift_r     <= 32'd0;
      pos_r       <= 32'd0;
      chunk_r     <= 32'd0;
      skip_r      <= 33'd0;
      fmt_r       <= 1'b0;
      format_r    <= 16'd0;
      ch_r        <= 16'd0;
      rate_r      <= 32'd0;
      bits_r      <= 16'd0;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      shift_r     <= shift_nxt;
      pos_r       <= pos_nxt;
      chunk_r     <= chunk_nxt;
      skip_r      <= skip_nxt;
      fmt_r       <= fmt_nxt;
      format_r    <= format_nxt;
      ch_r        <= ch_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    doff_r  <= doff_nxt;
    dsize_r <= dsize_nxt;
    bpf_r   <= bpf_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> sv/rwhp_ctrl.sv
// Controller: parse phase state machine issuing datapath commands
`default_nettype none
module rwhp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rwhp_pkg::in_item_t in_data,
  input  wire rwhp_pkg::stat_t   stat,
  output rwhp_pkg::cmd_t         cmd
);

  rwhp_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic accept, active, busy;

  always_comb begin
    busy      = (phase_r == rwhp_pkg::P_MUL) || (phase_r == rwhp_pkg::P_ZCHK) ||
                (phase_r == rwhp_pkg::P_DIV);
    in_ready  = !stat.out_pending && !busy;
    accept    = in_valid && in_ready;
    phase_eff = (accept && in_data.first_byte) ? rwhp_pkg::P_RIFF : phase_r;
    active    = accept && (phase_eff != rwhp_pkg::P_IDLE) &&
                (phase_eff != rwhp_pkg::P_DONE);
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_src  = rwhp_pkg::SRC_ZERO;
    cmd.clear     = accept && in_data.first_byte;
    cmd.pos_inc   = active;
    cmd.gather_en = active && (phase_eff != rwhp_pkg::P_SKIP);
    if (active) begin
      case (phase_eff)
        rwhp_pkg::P_RIFF: begin
          if (stat.field_done && !stat.tag_riff) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = rwhp_pkg::ST_NO_RIFF;
          end
        end
        rwhp_pkg::P_WAVE: begin
          if (stat.field_done && !stat.tag_wave) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = rwhp_pkg::ST_NO_WAVE;
          end
        end
        rwhp_pkg::P_SZ_FMT: begin
          cmd.ld_chunk = stat.field_done;
          if (stat.field_done && stat.size_lt16) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = rwhp_pkg::ST_FMT_SHORT;
          end
        end
        rwhp_pkg::P_SZ_DATA: begin
          cmd.ld_data = stat.field_done;
          if (stat.field_done && (!stat.fmt_seen || !stat.cfg_match)) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = rwhp_pkg::SRC_NOW;
            cmd.emit_status = stat.fmt_seen ? rwhp_pkg::ST_MISMATCH :
                                              rwhp_pkg::ST_CHUNK_MISSING;
          end
        end
        rwhp_pkg::P_SZ_OTHER: begin
          cmd.ld_chunk      = stat.field_done;
          cmd.ld_skip_other = stat.field_done;
        end
        rwhp_pkg::P_F_FORMAT: begin
          cmd.gather_n2 = 1'b1;
          cmd.ld_format = stat.field_done;
        end
        rwhp_pkg::P_F_CHAN: begin
          cmd.gather_n2 = 1'b1;
          cmd.ld_chan   = stat.field_done;
        end
        rwhp_pkg::P_F_RATE: cmd.ld_rate = stat.field_done;
        rwhp_pkg::P_F_ALIGN: cmd.gather_n2 = 1'b1;
        rwhp_pkg::P_F_BITS: begin
          cmd.gather_n2 = 1'b1;
          cmd.ld_bits   = stat.field_done;
          if (stat.field_done) begin
            if (!stat.format_pcm) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = rwhp_pkg::ST_NOT_PCM;
            end else begin
              cmd.set_fmt     = 1'b1;
              cmd.ld_skip_fmt = 1'b1;
            end
          end
        end
        rwhp_pkg::P_SKIP: cmd.skip_dec = 1'b1;
        default: ;
      endcase
      if (in_data.last_byte && !cmd.emit && !cmd.ld_data) begin
        cmd.emit        = 1'b1;
        cmd.emit_src    = rwhp_pkg::SRC_ZERO;
        cmd.emit_status = rwhp_pkg::ST_CHUNK_MISSING;
      end
    end else begin
      case (phase_r)
        rwhp_pkg::P_MUL: cmd.mul_go = 1'b1;
        rwhp_pkg::P_ZCHK: begin
          if (stat.bpf_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = rwhp_pkg::SRC_HELD;
            cmd.emit_status = rwhp_pkg::ST_ZERO_FRAME;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
        rwhp_pkg::P_DIV: begin
          cmd.div_step = 1'b1;
          if (stat.div_last) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = rwhp_pkg::SRC_HELD;
            cmd.emit_status = rwhp_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_eff;
    if (active) begin
      case (phase_eff)
        rwhp_pkg::P_RIFF:     if (stat.field_done) phase_nxt = rwhp_pkg::P_RIFFSIZE;
        rwhp_pkg::P_RIFFSIZE: if (stat.field_done) phase_nxt = rwhp_pkg::P_WAVE;
        rwhp_pkg::P_WAVE:     if (stat.field_done) phase_nxt = rwhp_pkg::P_ID;
        rwhp_pkg::P_ID: begin
          if (stat.field_done) begin
            if (stat.tag_fmt) phase_nxt = rwhp_pkg::P_SZ_FMT;
            else if (stat.tag_data) phase_nxt = rwhp_pkg::P_SZ_DATA;
            else phase_nxt = rwhp_pkg::P_SZ_OTHER;
          end
        end
        rwhp_pkg::P_SZ_FMT:   if (stat.field_done) phase_nxt = rwhp_pkg::P_F_FORMAT;
        rwhp_pkg::P_SZ_DATA:  if (stat.field_done) phase_nxt = rwhp_pkg::P_MUL;
        rwhp_pkg::P_SZ_OTHER: begin
          if (stat.field_done)
            phase_nxt = stat.size_zero ? rwhp_pkg::P_ID : rwhp_pkg::P_SKIP;
        end
        rwhp_pkg::P_F_FORMAT: if (stat.field_done) phase_nxt = rwhp_pkg::P_F_CHAN;
        rwhp_pkg::P_F_CHAN:   if (stat.field_done) phase_nxt = rwhp_pkg::P_F_RATE;
        rwhp_pkg::P_F_RATE:   if (stat.field_done) phase_nxt = rwhp_pkg::P_F_BRATE;
        rwhp_pkg::P_F_BRATE:  if (stat.field_done) phase_nxt = rwhp_pkg::P_F_ALIGN;
        rwhp_pkg::P_F_ALIGN:  if (stat.field_done) phase_nxt = rwhp_pkg::P_F_BITS;
        rwhp_pkg::P_F_BITS: begin
          if (stat.field_done)
            phase_nxt = stat.fmt_rest_zero ? rwhp_pkg::P_ID : rwhp_pkg::P_SKIP;
        end
        rwhp_pkg::P_SKIP:     if (stat.skip_last) phase_nxt = rwhp_pkg::P_ID;
        default: ;
      endcase
    end else begin
      case (phase_r)
        rwhp_pkg::P_MUL:  phase_nxt = rwhp_pkg::P_ZCHK;
        rwhp_pkg::P_ZCHK: phase_nxt = rwhp_pkg::P_DIV;
        default: ;
      endcase
    end
    if (cmd.emit) phase_nxt = rwhp_pkg::P_DONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rwhp_pkg::P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Testbench for the RIFF/WAVE header parser: random and directed byte streams checked by a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rwhp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rwhp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = rwhp_pkg::CFG_CHANNELS;
  logic [31:0] cfg_wdata = '0;

  riff_wave_header_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] want_chan;
  logic [31:0] want_rate;
  logic [15:0] want_bits;
  rwhp_pkg::phase_t ph;
  logic [1:0]  fidx;
  logic [31:0] fshift;
  logic [31:0] bpos;
  logic [31:0] csize;
  logic [32:0] skip_left;
  logic        fmt_ok;
  logic [15:0] fcode;
  logic [15:0] h_chan;
  logic [31:0] h_rate;
  logic [15:0] h_bits;

  rwhp_pkg::in_item_t  byte_queue[$];
  rwhp_pkg::out_item_t header_results[$];
  logic      failed = 1'b0;
  logic      quiet_tail = 1'b0;
  logic      hold_out = 1'b0;
  int        hold_cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        stall_count = 0;
  int        file_count = 0;

  function automatic logic gather_byte(input logic [7:0] b, input int n);
    fshift = fshift | (32'(b) << (8 * fidx));
    if (int'(fidx) + 1 >= n) begin
      fidx = 2'd0;
      return 1'b1;
    end
    fidx = fidx + 2'd1;
    return 1'b0;
  endfunction

  function automatic void clear_parse();
    fidx = '0; fshift = '0; bpos = '0; csize = '0; skip_left = '0; fmt_ok = 1'b0;
    fcode = '0; h_chan = '0; h_rate = '0; h_bits = '0;
  endfunction

  function automatic void post_result(input logic [2:0] st, input logic [31:0] off,
                                      input logic [31:0] sz, input logic [31:0] fr);
    rwhp_pkg::out_item_t r;
    r.status = st; r.channel_count = h_chan; r.rate_hz = h_rate;
    r.sample_bits = h_bits; r.pcm_offset = off; r.data_size = sz; r.frame_count = fr;
    header_results.push_back(r);
    ph = rwhp_pkg::P_DONE;
  endfunction

  function automatic void post_data(input logic [31:0] sz);
    logic [31:0] off;
    logic [31:0] bpf;
    off = bpos + 32'd1;
    bpf = 32'(h_bits / 16'd8) * 32'(h_chan);
    if (!fmt_ok) post_result(rwhp_pkg::ST_CHUNK_MISSING, off, sz, 32'd0);
    else if (h_chan != want_chan || h_rate != want_rate || h_bits != want_bits)
      post_result(rwhp_pkg::ST_MISMATCH, off, sz, 32'd0);
    else if (bpf == 32'd0) post_result(rwhp_pkg::ST_ZERO_FRAME, off, sz, 32'd0);
    else post_result(rwhp_pkg::ST_OK, off, sz, sz / bpf);
  endfunction

  function automatic logic parse_byte(input logic [7:0] b);
    logic [31:0] v;
    case (ph)
      rwhp_pkg::P_RIFF: if (gather_byte(b, 4)) begin
        v = fshift; fshift = '0;
        if (v != rwhp_pkg::TAG_RIFF) begin
          post_result(rwhp_pkg::ST_NO_RIFF, 32'd0, 32'd0, 32'd0); return 1'b1;
        end
        ph = rwhp_pkg::P_RIFFSIZE;
      end
      rwhp_pkg::P_RIFFSIZE: if (gather_byte(b, 4)) begin
        fshift = '0; ph = rwhp_pkg::P_WAVE;
      end
      rwhp_pkg::P_WAVE: if (gather_byte(b, 4)) begin
        v = fshift; fshift = '0;
        if (v != rwhp_pkg::TAG_WAVE) begin
          post_result(rwhp_pkg::ST_NO_WAVE, 32'd0, 32'd0, 32'd0); return 1'b1;
        end
        ph = rwhp_pkg::P_ID;
      end
      rwhp_pkg::P_ID: if (gather_byte(b, 4)) begin
        v = fshift; fshift = '0;
        ph = (v == rwhp_pkg::TAG_FMT) ? rwhp_pkg::P_SZ_FMT :
             (v == rwhp_pkg::TAG_DATA) ? rwhp_pkg::P_SZ_DATA : rwhp_pkg::P_SZ_OTHER;
      end
      rwhp_pkg::P_SZ_FMT: if (gather_byte(b, 4)) begin
        csize = fshift; fshift = '0;
        if (csize < rwhp_pkg::FMT_BASE_LEN) begin
          post_result(rwhp_pkg::ST_FMT_SHORT, 32'd0, 32'd0, 32'd0); return 1'b1;
        end
        ph = rwhp_pkg::P_F_FORMAT;
      end
      rwhp_pkg::P_SZ_DATA: if (gather_byte(b, 4)) begin
        v = fshift; fshift = '0; post_data(v); return 1'b1;
      end
      rwhp_pkg::P_SZ_OTHER: if (gather_byte(b, 4)) begin
        csize = fshift; fshift = '0;
        skip_left = 33'(csize) + 33'(csize[0]);
        ph = (skip_left == 33'd0) ? rwhp_pkg::P_ID : rwhp_pkg::P_SKIP;
      end
      rwhp_pkg::P_F_FORMAT: if (gather_byte(b, 2)) begin
        fcode = fshift[15:0]; fshift = '0; ph = rwhp_pkg::P_F_CHAN;
      end
      rwhp_pkg::P_F_CHAN: if (gather_byte(b, 2)) begin
        h_chan = fshift[15:0]; fshift = '0; ph = rwhp_pkg::P_F_RATE;
      end
      rwhp_pkg::P_F_RATE: if (gather_byte(b, 4)) begin
        h_rate = fshift; fshift = '0; ph = rwhp_pkg::P_F_BRATE;
      end
      rwhp_pkg::P_F_BRATE: if (gather_byte(b, 4)) begin
        fshift = '0; ph = rwhp_pkg::P_F_ALIGN;
      end
      rwhp_pkg::P_F_ALIGN: if (gather_byte(b, 2)) begin
        fshift = '0; ph = rwhp_pkg::P_F_BITS;
      end
      rwhp_pkg::P_F_BITS: if (gather_byte(b, 2)) begin
        h_bits = fshift[15:0]; fshift = '0;
        if (fcode != rwhp_pkg::FMT_PCM) begin
          post_result(rwhp_pkg::ST_NOT_PCM, 32'd0, 32'd0, 32'd0); return 1'b1;
        end
        fmt_ok = 1'b1;
        skip_left = 33'(csize) - 33'(rwhp_pkg::FMT_BASE_LEN);
        ph = (skip_left == 33'd0) ? rwhp_pkg::P_ID : rwhp_pkg::P_SKIP;
      end
      rwhp_pkg::P_SKIP: begin
        if (skip_left > 33'd0) skip_left = skip_left - 33'd1;
        if (skip_left == 33'd0) ph = rwhp_pkg::P_ID;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_byte(input rwhp_pkg::in_item_t it);
    logic got;
    if (it.first_byte) begin clear_parse(); ph = rwhp_pkg::P_RIFF; end
    if (ph == rwhp_pkg::P_IDLE || ph == rwhp_pkg::P_DONE) return;
    got = parse_byte(it.file_byte);
    bpos = bpos + 32'd1;
    if (!got && it.last_byte)
      post_result(rwhp_pkg::ST_CHUNK_MISSING, 32'd0, 32'd0, 32'd0);
  endfunction

  // stimulus builders
  function automatic void push_byte(input logic [7:0] b, input logic f, input logic l);
    rwhp_pkg::in_item_t it;
    it.file_byte = b; it.first_byte = f; it.last_byte = l;
    byte_queue.push_back(it);
  endfunction

  function automatic void push_word(input logic [31:0] w, input int n);
    for (int k = 0; k < n; k++) push_byte(w[8*k +: 8], 1'b0, 1'b0);
  endfunction

  function automatic void push_fmt(input logic [31:0] sz, input logic [15:0] code,
                                   input logic [15:0] ch, input logic [31:0] rate,
                                   input logic [15:0] bits);
    push_word(rwhp_pkg::TAG_FMT, 4); push_word(sz, 4);
    push_word(32'(code), 2); push_word(32'(ch), 2); push_word(rate, 4);
    push_word($urandom, 4); push_word($urandom, 2); push_word(32'(bits), 2);
    for (int k = 16; k < int'(sz) && k < 40; k++) push_byte(8'($urandom), 1'b0, 1'b0);
  endfunction

  // build one file; shape picks good, broken or noisy streams
  function automatic void push_file(input int shape);
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] sz;
    int n;
    ch = ($urandom_range(0, 3) != 0) ? want_chan : 16'($urandom_range(0, 3));
    rate = ($urandom_range(0, 3) != 0) ? want_rate : $urandom;
    bits = ($urandom_range(0, 3) != 0) ? want_bits : 16'($urandom_range(0, 33));
    push_byte((shape == 1) ? 8'($urandom) : 8'(rwhp_pkg::TAG_RIFF), 1'b1, 1'b0);
    push_word(rwhp_pkg::TAG_RIFF >> 8, 3);
    push_word($urandom, 4);
    push_word((shape == 2) ? $urandom : rwhp_pkg::TAG_WAVE, 4);
    n = int'($urandom_range(0, 2));
    for (int c = 0; c < n; c++) begin
      sz = 32'($urandom_range(0, 9));
      push_word($urandom, 4); push_word(sz, 4);
      for (int k = 0; k < int'(sz + 32'(sz[0])); k++) push_byte(8'($urandom), 1'b0, 1'b0);
    end
    if (shape != 3) begin
      sz = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 15))
                                      : 32'($urandom_range(16, 24));
      push_fmt(sz, ($urandom_range(0, 7) == 0) ? 16'($urandom) : rwhp_pkg::FMT_PCM,
               ch, rate, bits);
    end
    push_word(rwhp_pkg::TAG_DATA, 4);
    if (shape == 4) push_byte(8'($urandom), 1'b0, 1'b1);
    else push_word($urandom, 4);
    for (int k = 0; k < int'($urandom_range(0, 3)); k++)
      push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rwhp_pkg::CFG_CHANNELS: want_chan = val[15:0];
      rwhp_pkg::CFG_RATE: want_rate = val;
      default: want_bits = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || header_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // driver: the queue front is the transaction on the bus until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_byte(in_data);
      if (!(in_valid && !in_ready)) begin
        if (in_valid && in_ready) void'(byte_queue.pop_front());
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
          in_gap <= int'($urandom_range(1, 14));
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= byte_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    rwhp_pkg::out_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (header_results.size() == 0) begin
          failed <= 1'b1;
          $display("%0t: unexpected result %p", $realtime, out_data);
        end else begin
          e = header_results.pop_front();
          if (e.status != out_data.status)
            $display("%0t: status exp %0d got %0d", $realtime, e.status, out_data.status);
          if (e.channel_count != out_data.channel_count)
            $display("%0t: channels exp %0d got %0d", $realtime, e.channel_count,
                     out_data.channel_count);
          if (e.rate_hz != out_data.rate_hz)
            $display("%0t: rate exp %0d got %0d", $realtime, e.rate_hz,
                     out_data.rate_hz);
          if (e.sample_bits != out_data.sample_bits)
            $display("%0t: bits exp %0d got %0d", $realtime, e.sample_bits,
                     out_data.sample_bits);
          if (e.pcm_offset != out_data.pcm_offset)
            $display("%0t: offset exp %0d got %0d", $realtime, e.pcm_offset,
                     out_data.pcm_offset);
          if (e.data_size != out_data.data_size)
            $display("%0t: size exp %0d got %0d", $realtime, e.data_size, out_data.data_size);
          if (e.frame_count != out_data.frame_count)
            $display("%0t: frames exp %0d got %0d", $realtime, e.frame_count,
                     out_data.frame_count);
          if (e != out_data) failed <= 1'b1;
        end
      end
      if (hold_out && hold_cycles < 400) begin
        hold_cycles <= hold_cycles + 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        out_gap <= int'($urandom_range(1, 14));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_count <= 0;
    else begin
      stall_count <= stall_count + 1;
      if (stall_count > 5000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    want_chan = rwhp_pkg::RST_CHANNELS;
    want_rate = rwhp_pkg::RST_RATE;
    want_bits = rwhp_pkg::RST_BITS;
    ph = rwhp_pkg::P_IDLE;
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ignored before any first byte, then truncated tags and extremes
    push_byte(8'hFF, 1'b0, 1'b1); push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h52, 1'b1, 1'b1);
    push_word(rwhp_pkg::TAG_RIFF, 4); push_word(32'hFFFF_FFFF, 4);
    push_word(rwhp_pkg::TAG_WAVE, 3);
    push_byte(8'(rwhp_pkg::TAG_WAVE >> 24), 1'b0, 1'b1);
    push_file(0);
    drain();

    // reset settings: data chunk without fmt, non-PCM fmt, then a file meeting them
    push_byte(8'(rwhp_pkg::TAG_RIFF), 1'b1, 1'b0); push_word(rwhp_pkg::TAG_RIFF >> 8, 3);
    push_word(32'd0, 4); push_word(rwhp_pkg::TAG_WAVE, 4);
    push_word(rwhp_pkg::TAG_DATA, 4); push_word(32'd8, 4);
    push_byte(8'(rwhp_pkg::TAG_RIFF), 1'b1, 1'b0); push_word(rwhp_pkg::TAG_RIFF >> 8, 3);
    push_word(32'd0, 4); push_word(rwhp_pkg::TAG_WAVE, 4);
    push_word(32'h1234_5678, 4); push_word(32'h0000_0003, 4); push_word(32'd0, 4);
    push_fmt(32'd18, 16'h0003, 16'd1, 32'd16000, 16'd16);
    push_byte(8'(rwhp_pkg::TAG_RIFF), 1'b1, 1'b0); push_word(rwhp_pkg::TAG_RIFF >> 8, 3);
    push_word(32'd0, 4); push_word(rwhp_pkg::TAG_WAVE, 4);
    push_fmt(32'd16, rwhp_pkg::FMT_PCM, 16'd2, 32'd8000, 16'd8);
    push_fmt(32'd17, rwhp_pkg::FMT_PCM, 16'd1, 32'd16000, 16'd16);
    push_word(rwhp_pkg::TAG_DATA, 4); push_word(32'hFFFF_FFFF, 4);
    drain();

    // odd huge unknown chunk, cut short by last byte
    push_byte(8'(rwhp_pkg::TAG_RIFF), 1'b1, 1'b0); push_word(rwhp_pkg::TAG_RIFF >> 8, 3);
    push_word(32'd0, 4); push_word(rwhp_pkg::TAG_WAVE, 4);
    push_word(32'h0BAD_F00D, 4); push_word(32'hFFFF_FFFF, 4);
    for (int k = 0; k < 5; k++) push_byte(8'($urandom), 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b1);
    drain();

    // hold off the receiver while the sender keeps offering
    hold_out = 1'b1;
    for (int f = 0; f < 4; f++) push_file(0);
    wait (hold_cycles >= 400);
    hold_out = 1'b0;
    drain();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'd1); write_reg(rwhp_pkg::CFG_RATE, 32'd1);
                 write_reg(rwhp_pkg::CFG_BITS, 32'd1); end
        1: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'hFFFF);
                 write_reg(rwhp_pkg::CFG_RATE, 32'hFFFF_FFFF);
                 write_reg(rwhp_pkg::CFG_BITS, 32'hFFFF); end
        2: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'd2);
                 write_reg(rwhp_pkg::CFG_RATE, 32'd44100);
                 write_reg(rwhp_pkg::CFG_BITS, 32'd16); end
        3: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'd3);
                 write_reg(rwhp_pkg::CFG_RATE, 32'd48000);
                 write_reg(rwhp_pkg::CFG_BITS, 32'd24); end
        4: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'($urandom_range(1, 8)));
                 write_reg(rwhp_pkg::CFG_RATE, $urandom);
                 write_reg(rwhp_pkg::CFG_BITS, 32'd7); end
        default: begin write_reg(rwhp_pkg::CFG_CHANNELS, 32'd1);
                 write_reg(rwhp_pkg::CFG_RATE, 32'd8000);
                 write_reg(rwhp_pkg::CFG_BITS, 32'd8); end
      endcase
      for (int f = 0; f < 3; f++) begin
        file_count = int'($urandom_range(0, 9));
        push_file((file_count < 6) ? 0 : file_count - 5);
      end
      if (s == 5) quiet_tail = 1'b1;
      drain();
    end

    if (!failed) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

>>> riff_wave_header_parser.f
+incdir+sv
sv/rwhp_pkg.sv
sv/rwhp_dpath.sv
sv/rwhp_ctrl.sv
sv/riff_wave_header_parser.sv
bench/tb.sv
